>>> hw/rtl/lcpf_pkg.sv
// Shared constants, payload types and register codes for the pair force pipeline.
// Used by the channel interfaces, the arithmetic units and the top level.
package lcpf_pkg;

	// Fraction bits of every fixed-point quantity (Q.F).
	localparam int FRAC_BITS = 24;

	// Iterative units: one root bit per step, one quotient bit per step.
	localparam int ROOT_W     = 32;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int INV_W      = 2 * FRAC_BITS + 1;
	localparam int DIV_STEPS  = INV_W;
	localparam int MUL_LAT    = 2;

	localparam logic [63:0] WIDE_CAP  = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CAP_DIV2  = WIDE_CAP / 2;
	localparam logic [63:0] CAP_DIV4  = WIDE_CAP / 4;
	localparam logic [63:0] CAP_DIV24 = WIDE_CAP / 24;

	localparam logic signed [47:0] OUT_MAX   = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] OUT_MIN   = -48'sh7FFF_FFFF_FFFF - 48'sd1;
	localparam logic signed [63:0] OUT_MAX_W = 64'sd140737488355327;
	localparam logic signed [63:0] OUT_MIN_W = -64'sd140737488355328;

	// Configuration register indexes.
	localparam logic [2:0] REG_BOX_SIZE        = 3'd0;
	localparam logic [2:0] REG_OXYGEN_SIGMA    = 3'd1;
	localparam logic [2:0] REG_OXYGEN_EPSILON  = 3'd2;
	localparam logic [2:0] REG_HYDROGEN_CHARGE = 3'd3;
	localparam logic [2:0] REG_OXYGEN_CHARGE   = 3'd4;
	localparam logic [2:0] REG_COULOMB_SCALE   = 3'd5;

	// Periodic image codes, two bits per axis.
	localparam logic [1:0] IMG_ADD = 2'b01;
	localparam logic [1:0] IMG_SUB = 2'b10;

	localparam logic [30:0] RST_BOX_SIZE        = 31'd50331648;
	localparam logic [30:0] RST_OXYGEN_SIGMA    = 31'd5310945;
	localparam logic [30:0] RST_OXYGEN_EPSILON  = 31'd10908445;
	localparam logic [31:0] RST_HYDROGEN_CHARGE = 32'd6878659;
	localparam logic [31:0] RST_OXYGEN_CHARGE   = 32'hFF2E_147B;
	localparam logic [31:0] RST_COULOMB_SCALE   = 32'd2331026391;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic               first_is_oxygen;
		logic               second_is_oxygen;
		logic [5:0]         image_code;
		logic               batch_end;
	} pair_t;

	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [47:0] pair_energy;
		logic               zero_distance;
		logic               batch_end_out;
	} result_t;

endpackage

>>> hw/rtl/lcpf_intf.sv
// Valid/ready channel interfaces for pair beats, result beats and register writes.
// Depends on lcpf_pkg for the payload types.
interface lcpf_pair_if;
	logic              valid;
	logic              ready;
	lcpf_pkg::pair_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcpf_result_if;
	logic              valid;
	logic              ready;
	lcpf_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcpf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [31:0] wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hw/rtl/lj_coulomb_pair_force_top.sv
// Lennard-Jones plus Coulomb pair force pipeline, top level.
// Depends on lcpf_pkg, lcpf_intf, lcpf_qmul, lcpf_sqrt and lcpf_recip.
//
// This block takes one atom pair per clock unless the result channel stalls, and
// returns, for each pair, the force on the first atom and the pair energy in
// saturating Q24.24, plus a zero-distance flag and a copy of the batch marker.
// Results leave in the order pairs arrive. After the image, squaring and sum stages come
// the 32-step square-root pipeline and the reciprocal divider, which retires one
// quotient bit per stage, followed by seven levels of two-stage multipliers. The whole
// pipeline advances together whenever the output register is empty or its beat is
// taken, so a stall on the result channel holds every stage in place and the input
// stops accepting beats until the stall clears. Registers are written through the
// configuration channel, which always accepts a beat; write them only while no pair
// is in flight. Writes to indexes past the last register are ignored.
module lj_coulomb_pair_force_top (
	input  logic                 clk,
	input  logic                 arst_n,
	lcpf_pair_if.sink            pair_in,
	lcpf_result_if.source        result_out,
	lcpf_cfg_if.sink             cfg
);

	localparam int MUL_LAT = lcpf_pkg::MUL_LAT;
	// Stage numbers; stage k sits in sb_s[k-1].
	localparam int ST_R2   = 3;
	localparam int ST_ROOT = ST_R2 + lcpf_pkg::SQRT_STEPS;
	localparam int ST_INV  = ST_ROOT + lcpf_pkg::DIV_STEPS;
	localparam int ST_QQ   = ST_INV - 2 * MUL_LAT;
	localparam int ST_L1   = ST_INV;
	localparam int ST_L2   = ST_L1 + MUL_LAT;
	localparam int ST_L3   = ST_L2 + MUL_LAT;
	localparam int ST_L4   = ST_L3 + MUL_LAT;
	localparam int ST_L5   = ST_L4 + MUL_LAT;
	localparam int ST_L6   = ST_L5 + MUL_LAT + 1;
	localparam int ST_SUM  = ST_L6 + MUL_LAT + 1;
	localparam int ST_L7   = ST_SUM;
	localparam int NSTG    = ST_L7 + MUL_LAT + 1;

	localparam int KQ_DLY  = ST_L2 - ST_INV;
	localparam int INV_DLY = ST_L3 - ST_L1;
	localparam int X2_DLY  = ST_L4 - ST_L3;
	localparam int X6_DLY  = ST_L6 - 1 - (ST_L4 + MUL_LAT);
	localparam int EI2_DLY = ST_L6 - ST_L3;
	localparam int EC_DLY  = ST_SUM - 1 - ST_L2;
	localparam int TB_DLY  = ST_SUM - 1 - ST_L4;
	localparam int D_DLY   = ST_SUM - 1 - ST_L6;
	localparam int F_DLY   = MUL_LAT;

	typedef struct packed {
		logic [2:0][32:0] mag;
		logic [2:0]       dneg;
		logic [1:0]       sh;
		logic             zero;
		logic             first_oxy;
		logic             second_oxy;
		logic             batch;
	} side_t;

	// Configuration registers.
	logic [30:0] box_q, sigma_q, epsilon_q;
	logic [31:0] hcharge_q, ocharge_q, kscale_q;

	// Pipeline control and side data.
	logic            adv;
	logic [NSTG-1:0] vld_s;
	side_t           sb_s [NSTG];
	side_t           side_in;

	assign adv           = !vld_s[NSTG-1] || result_out.ready;
	assign pair_in.ready = adv;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q     <= lcpf_pkg::RST_BOX_SIZE;
			sigma_q   <= lcpf_pkg::RST_OXYGEN_SIGMA;
			epsilon_q <= lcpf_pkg::RST_OXYGEN_EPSILON;
			hcharge_q <= lcpf_pkg::RST_HYDROGEN_CHARGE;
			ocharge_q <= lcpf_pkg::RST_OXYGEN_CHARGE;
			kscale_q  <= lcpf_pkg::RST_COULOMB_SCALE;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				lcpf_pkg::REG_BOX_SIZE:        box_q     <= cfg.wdata[30:0];
				lcpf_pkg::REG_OXYGEN_SIGMA:    sigma_q   <= cfg.wdata[30:0];
				lcpf_pkg::REG_OXYGEN_EPSILON:  epsilon_q <= cfg.wdata[30:0];
				lcpf_pkg::REG_HYDROGEN_CHARGE: hcharge_q <= cfg.wdata;
				lcpf_pkg::REG_OXYGEN_CHARGE:   ocharge_q <= cfg.wdata;
				lcpf_pkg::REG_COULOMB_SCALE:   kscale_q  <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], pair_in.valid};
		end
	end

	// Stage 1: periodic image shift, separation vector, magnitudes and prescale.
	logic signed [31:0] pos_i [3];
	logic signed [31:0] pos_j [3];
	logic signed [33:0] pi_x, pj_x, box_x, dvec, nvec;

	always_comb begin
		pos_i[0] = pair_in.data.first_x;
		pos_i[1] = pair_in.data.first_y;
		pos_i[2] = pair_in.data.first_z;
		pos_j[0] = pair_in.data.second_x;
		pos_j[1] = pair_in.data.second_y;
		pos_j[2] = pair_in.data.second_z;
		box_x    = {3'b000, box_q};
		side_in  = '0;
		for (int ax = 0; ax < 3; ax++) begin
			pi_x = {{2{pos_i[ax][31]}}, pos_i[ax]};
			pj_x = {{2{pos_j[ax][31]}}, pos_j[ax]};
			case (pair_in.data.image_code[2*ax +: 2])
				lcpf_pkg::IMG_ADD: pj_x = pj_x + box_x;
				lcpf_pkg::IMG_SUB: pj_x = pj_x - box_x;
				default: begin
				end
			endcase
			dvec = pj_x - pi_x;
			nvec = -dvec;
			side_in.dneg[ax] = dvec[33];
			side_in.mag[ax]  = dvec[33] ? nvec[32:0] : dvec[32:0];
		end
		side_in.zero = (side_in.mag == '0);
		if (side_in.mag[0][32] || side_in.mag[1][32] || side_in.mag[2][32]) begin
			side_in.sh = 2'd2;
		end else if (side_in.mag[0][31] || side_in.mag[1][31] || side_in.mag[2][31]) begin
			side_in.sh = 2'd1;
		end else begin
			side_in.sh = 2'd0;
		end
		side_in.first_oxy  = pair_in.data.first_is_oxygen;
		side_in.second_oxy = pair_in.data.second_is_oxygen;
		side_in.batch      = pair_in.data.batch_end;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= side_in;
			for (int k = 1; k < NSTG; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	// Stages 2 and 3: squared components, then their sum.
	logic [61:0] sq_s2 [3];
	logic [30:0] scaled [3];
	logic [63:0] r2_s3;

	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			scaled[ax] = 31'(sb_s[0].mag[ax] >> sb_s[0].sh);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ax = 0; ax < 3; ax++) begin
				sq_s2[ax] <= scaled[ax] * scaled[ax];
			end
			r2_s3 <= 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
		end
	end

	// Distance and its reciprocal; the divisor undoes the prescale.
	logic [31:0]                 root;
	logic [33:0]                 divisor;
	logic [lcpf_pkg::INV_W-1:0]  inv_raw;
	logic [63:0]                 inv;

	lcpf_sqrt u_sqrt (.clk(clk), .en(adv), .rad(r2_s3), .root(root));

	assign divisor = 34'(root) << sb_s[ST_ROOT-1].sh;

	lcpf_recip u_recip (.clk(clk), .en(adv), .divisor(divisor), .quot(inv_raw));

	assign inv = 64'(inv_raw);

	// Charge product, formed just in time from the pair types.
	logic [31:0] qa_v, qb_v, qa_m, qb_m;
	logic [63:0] qq, kq;

	always_comb begin
		qa_v = sb_s[ST_QQ-1].first_oxy ? ocharge_q : hcharge_q;
		qb_v = sb_s[ST_QQ-1].second_oxy ? ocharge_q : hcharge_q;
		qa_m = qa_v[31] ? 32'(-qa_v) : qa_v;
		qb_m = qb_v[31] ? 32'(-qb_v) : qb_v;
	end

	lcpf_qmul u_qq (.clk(clk), .en(adv), .a(64'(qa_m)), .b(64'(qb_m)), .prod(qq));
	lcpf_qmul u_kq (.clk(clk), .en(adv), .a(64'(kscale_q)), .b(qq), .prod(kq));

	// Lennard-Jones parameters, zero unless both atoms are oxygen.
	logic [63:0] sig_l1, eps_l2, eps_l6;

	always_comb begin
		sig_l1 = (sb_s[ST_L1-1].first_oxy && sb_s[ST_L1-1].second_oxy) ? 64'(sigma_q) : '0;
		eps_l2 = (sb_s[ST_L2-1].first_oxy && sb_s[ST_L2-1].second_oxy) ? 64'(epsilon_q) : '0;
		eps_l6 = (sb_s[ST_L6-1].first_oxy && sb_s[ST_L6-1].second_oxy) ? 64'(epsilon_q) : '0;
	end

	// Delay lines that line operands up with the multiplier levels.
	logic [63:0] kq_dly_q  [KQ_DLY];
	logic [63:0] inv_dly_q [INV_DLY];
	logic [63:0] x2_dly_q  [X2_DLY];
	logic [63:0] x6_dly_q  [X6_DLY];
	logic [63:0] ei2_dly_q [EI2_DLY];
	logic [63:0] ec_dly_q  [EC_DLY];
	logic [63:0] tb_dly_q  [TB_DLY];
	logic [D_DLY-1:0] d1n_dly_q, d2n_dly_q;
	logic [F_DLY-1:0] fn_dly_q;
	logic signed [63:0] en_dly_q [F_DLY];

	// Power chain and Coulomb terms.
	logic [63:0] inv2, x, ec, x2, ei2, kq2, x4, tbm, x6, x12;

	lcpf_qmul u_inv2 (.clk(clk), .en(adv), .a(inv), .b(inv), .prod(inv2));
	lcpf_qmul u_x (.clk(clk), .en(adv), .a(sig_l1), .b(inv), .prod(x));
	lcpf_qmul u_ec (.clk(clk), .en(adv), .a(kq), .b(inv), .prod(ec));
	lcpf_qmul u_x2 (.clk(clk), .en(adv), .a(x), .b(x), .prod(x2));
	lcpf_qmul u_ei2 (.clk(clk), .en(adv), .a(eps_l2), .b(inv2), .prod(ei2));
	lcpf_qmul u_kq2 (.clk(clk), .en(adv), .a(kq_dly_q[KQ_DLY-1]), .b(inv2), .prod(kq2));
	lcpf_qmul u_x4 (.clk(clk), .en(adv), .a(x2), .b(x2), .prod(x4));
	lcpf_qmul u_tb (.clk(clk), .en(adv), .a(kq2), .b(inv_dly_q[INV_DLY-1]), .prod(tbm));
	lcpf_qmul u_x6 (.clk(clk), .en(adv), .a(x4), .b(x2_dly_q[X2_DLY-1]), .prod(x6));
	lcpf_qmul u_x12 (.clk(clk), .en(adv), .a(x6), .b(x6), .prod(x12));

	// Lennard-Jones differences. When the twelfth power saturates, the difference
	// saturates toward that term.
	logic signed [63:0] d1, dd, d2;
	logic [63:0]        x6d, k2;
	logic [63:0]        d1_mag_s95, d2_mag_s95;
	logic               d1_neg_s95, d2_neg_s95;

	always_comb begin
		x6d = x6_dly_q[X6_DLY-1];
		d1  = (x12 >= lcpf_pkg::WIDE_CAP) ? $signed(lcpf_pkg::WIDE_CAP)
			: $signed(x12) - $signed(x6d);
		k2  = (x12 > lcpf_pkg::CAP_DIV2) ? lcpf_pkg::WIDE_CAP : {x12[62:0], 1'b0};
		dd  = (k2 >= lcpf_pkg::WIDE_CAP) ? $signed(lcpf_pkg::WIDE_CAP)
			: $signed(k2) - $signed(x6d);
		d2  = -dd;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_neg_s95 <= d1[63];
			d1_mag_s95 <= d1[63] ? 64'(-d1) : d1;
			d2_neg_s95 <= d2[63];
			d2_mag_s95 <= d2[63] ? 64'(-d2) : d2;
		end
	end

	logic [63:0] m1, m2;

	lcpf_qmul u_m1 (.clk(clk), .en(adv), .a(eps_l6), .b(d1_mag_s95), .prod(m1));
	lcpf_qmul u_m2 (.clk(clk), .en(adv), .a(ei2_dly_q[EI2_DLY-1]), .b(d2_mag_s95),
		.prod(m2));

	// Energy sum and scalar force.
	logic [31:0]        ca_v, cb_v;
	logic               negq;
	logic [63:0]        elj_m, ta_m, ecm, tbmd;
	logic signed [63:0] elj, ecoul, ta, tb, fs;
	logic signed [63:0] energy_s98;
	logic [63:0]        fs_mag_s98;
	logic               fs_neg_s98;

	always_comb begin
		ca_v  = sb_s[ST_SUM-2].first_oxy ? ocharge_q : hcharge_q;
		cb_v  = sb_s[ST_SUM-2].second_oxy ? ocharge_q : hcharge_q;
		negq  = ca_v[31] ^ cb_v[31];
		elj_m = (m1 > lcpf_pkg::CAP_DIV4) ? lcpf_pkg::WIDE_CAP : {m1[61:0], 2'b00};
		ta_m  = (m2 > lcpf_pkg::CAP_DIV24) ? lcpf_pkg::WIDE_CAP : 64'(m2 * 64'd24);
		ecm   = ec_dly_q[EC_DLY-1];
		tbmd  = tb_dly_q[TB_DLY-1];
		elj   = d1n_dly_q[D_DLY-1] ? -$signed(elj_m) : $signed(elj_m);
		ta    = d2n_dly_q[D_DLY-1] ? -$signed(ta_m) : $signed(ta_m);
		ecoul = negq ? -$signed(ecm) : $signed(ecm);
		tb    = negq ? -$signed(tbmd) : $signed(tbmd);
		fs    = ta - tb;
		if (fs > $signed(lcpf_pkg::WIDE_CAP)) begin
			fs = $signed(lcpf_pkg::WIDE_CAP);
		end else if (fs < -$signed(lcpf_pkg::WIDE_CAP)) begin
			fs = -$signed(lcpf_pkg::WIDE_CAP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			energy_s98 <= elj + ecoul;
			fs_neg_s98 <= fs[63];
			fs_mag_s98 <= fs[63] ? 64'(-fs) : fs;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kq_dly_q[0]  <= kq;
			inv_dly_q[0] <= inv;
			x2_dly_q[0]  <= x2;
			x6_dly_q[0]  <= x6;
			ei2_dly_q[0] <= ei2;
			ec_dly_q[0]  <= ec;
			tb_dly_q[0]  <= tbm;
			en_dly_q[0]  <= energy_s98;
			for (int k = 1; k < KQ_DLY; k++) kq_dly_q[k] <= kq_dly_q[k-1];
			for (int k = 1; k < INV_DLY; k++) inv_dly_q[k] <= inv_dly_q[k-1];
			for (int k = 1; k < X2_DLY; k++) x2_dly_q[k] <= x2_dly_q[k-1];
			for (int k = 1; k < X6_DLY; k++) x6_dly_q[k] <= x6_dly_q[k-1];
			for (int k = 1; k < EI2_DLY; k++) ei2_dly_q[k] <= ei2_dly_q[k-1];
			for (int k = 1; k < EC_DLY; k++) ec_dly_q[k] <= ec_dly_q[k-1];
			for (int k = 1; k < TB_DLY; k++) tb_dly_q[k] <= tb_dly_q[k-1];
			for (int k = 1; k < F_DLY; k++) en_dly_q[k] <= en_dly_q[k-1];
			d1n_dly_q <= {d1n_dly_q[D_DLY-2:0], d1_neg_s95};
			d2n_dly_q <= {d2n_dly_q[D_DLY-2:0], d2_neg_s95};
			fn_dly_q  <= {fn_dly_q[F_DLY-2:0], fs_neg_s98};
		end
	end

	// Force components along the separation vector.
	logic [63:0] fmag [3];

	for (genvar ax = 0; ax < 3; ax++) begin : g_force
		lcpf_qmul u_f (.clk(clk), .en(adv), .a(64'(sb_s[ST_L7-1].mag[ax])), .b(fs_mag_s98),
			.prod(fmag[ax]));
	end

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > lcpf_pkg::OUT_MAX_W) begin
			r = lcpf_pkg::OUT_MAX;
		end else if (v < lcpf_pkg::OUT_MIN_W) begin
			r = lcpf_pkg::OUT_MIN;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	// Output register: the result beat waits here until taken.
	side_t              sb_last;
	logic signed [47:0] fout [3];
	logic               fneg;
	lcpf_pkg::result_t  res_s101;

	always_comb begin
		sb_last = sb_s[NSTG-2];
		fneg    = fn_dly_q[F_DLY-1];
		for (int ax = 0; ax < 3; ax++) begin
			fout[ax] = sat48((sb_last.dneg[ax] != fneg) ? -$signed(fmag[ax])
				: $signed(fmag[ax]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s101.batch_end_out <= sb_last.batch;
			res_s101.zero_distance <= sb_last.zero;
			if (sb_last.zero) begin
				res_s101.force_x     <= lcpf_pkg::OUT_MAX;
				res_s101.force_y     <= lcpf_pkg::OUT_MAX;
				res_s101.force_z     <= lcpf_pkg::OUT_MAX;
				res_s101.pair_energy <= lcpf_pkg::OUT_MAX;
			end else begin
				res_s101.force_x     <= fout[0];
				res_s101.force_y     <= fout[1];
				res_s101.force_z     <= fout[2];
				res_s101.pair_energy <= sat48(en_dly_q[F_DLY-1]);
			end
		end
	end

	assign result_out.valid = vld_s[NSTG-1];
	assign result_out.data  = res_s101;

`ifndef SYNTHESIS
	// A zero-distance result carries saturated force and energy.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.data.zero_distance |->
		result_out.data.force_x == lcpf_pkg::OUT_MAX &&
		result_out.data.pair_energy == lcpf_pkg::OUT_MAX)
		else $error("zero-distance result is not saturated");

	// A stall freezes every stage's valid bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during a stall");

	// When the pipeline advances, valid bits move one stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s[NSTG-1:1] == $past(vld_s[NSTG-2:0]))
		else $error("valid bit lost or duplicated between stages");

	// An accepted pair beat enters the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		pair_in.valid && pair_in.ready |=> vld_s[0])
		else $error("accepted pair did not enter the pipeline");
`endif

endmodule

>>> hw/rtl/lcpf_qmul.sv
// Two-stage fixed-point multiplier: 32x32 partial products, then sum, shift and cap.
// Depends on lcpf_pkg for the fraction width and the saturation cap.
module lcpf_qmul (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] prod
);

	logic [63:0]  pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic [127:0] full;
	logic [127:0] shifted;
	logic [63:0]  prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= a[31:0] * b[31:0];
			pp01_s1 <= a[31:0] * b[63:32];
			pp10_s1 <= a[63:32] * b[31:0];
			pp11_s1 <= a[63:32] * b[63:32];
		end
	end

	always_comb begin
		full = {64'b0, pp00_s1} + {32'b0, pp01_s1, 32'b0} + {32'b0, pp10_s1, 32'b0}
			+ {pp11_s1, 64'b0};
		shifted = full >> lcpf_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (shifted > {64'b0, lcpf_pkg::WIDE_CAP}) ? lcpf_pkg::WIDE_CAP
				: shifted[63:0];
		end
	end

	assign prod = prod_s2;

endmodule

>>> hw/rtl/lcpf_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on lcpf_pkg for the step count.
module lcpf_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	localparam int N = lcpf_pkg::SQRT_STEPS;

	logic [63:0] rad_s  [N];
	logic [33:0] rem_s  [N];
	logic [31:0] root_s [N];
	logic [63:0] rad_n  [N];
	logic [33:0] rem_n  [N];
	logic [31:0] root_n [N];
	logic [63:0] rad_p;
	logic [33:0] rem_p;
	logic [31:0] root_p;
	logic [35:0] rem_t;
	logic [35:0] trial;
	logic [35:0] diff;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				rad_p  = rad;
				rem_p  = '0;
				root_p = '0;
			end else begin
				rad_p  = rad_s[k-1];
				rem_p  = rem_s[k-1];
				root_p = root_s[k-1];
			end
			rem_t = {rem_p, rad_p[63:62]};
			trial = {2'b00, root_p, 2'b01};
			diff  = rem_t - trial;
			if (rem_t >= trial) begin
				rem_n[k]  = diff[33:0];
				root_n[k] = {root_p[30:0], 1'b1};
			end else begin
				rem_n[k]  = rem_t[33:0];
				root_n[k] = {root_p[30:0], 1'b0};
			end
			rad_n[k] = {rad_p[61:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rad_s[k]  <= rad_n[k];
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
			end
		end
	end

	assign root = root_s[N-1];

endmodule

>>> hw/rtl/lcpf_recip.sv
// Pipelined restoring divider that forms 2^(2F) / divisor, one quotient bit per stage.
// Depends on lcpf_pkg for the quotient width and the step count.
module lcpf_recip (
	input  logic                        clk,
	input  logic                        en,
	input  logic [33:0]                 divisor,
	output logic [lcpf_pkg::INV_W-1:0]  quot
);

	localparam int N = lcpf_pkg::DIV_STEPS;
	localparam int W = lcpf_pkg::INV_W;

	logic [33:0]  dvs_s [N];
	logic [33:0]  rem_s [N];
	logic [W-1:0] quo_s [N];
	logic [33:0]  rem_n [N];
	logic [W-1:0] quo_n [N];
	logic [33:0]  dvs_p;
	logic [33:0]  rem_p;
	logic [W-1:0] quo_p;
	logic [34:0]  rem_t;
	logic [34:0]  diff;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				dvs_p = divisor;
				rem_p = '0;
				quo_p = '0;
			end else begin
				dvs_p = dvs_s[k-1];
				rem_p = rem_s[k-1];
				quo_p = quo_s[k-1];
			end
			// The dividend is a single one at its top bit.
			rem_t = {rem_p, (k == 0)};
			diff  = rem_t - {1'b0, dvs_p};
			if (rem_t >= {1'b0, dvs_p}) begin
				rem_n[k] = diff[33:0];
				quo_n[k] = {quo_p[W-2:0], 1'b1};
			end else begin
				rem_n[k] = rem_t[33:0];
				quo_n[k] = {quo_p[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				dvs_s[k] <= (k == 0) ? divisor : dvs_s[k-1];
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end

	assign quot = quo_s[N-1];

endmodule

>>> bench/tb_lj_coulomb_pair_force_top.sv
// Self-checking bench for the Lennard-Jones plus Coulomb pair force pipeline.
// Depends on lcpf_pkg, lcpf_intf and lj_coulomb_pair_force_top, which needs lcpf_qmul, lcpf_sqrt and lcpf_recip.
`timescale 1ns / 100ps

module tb_lj_coulomb_pair_force_top;

	localparam logic [63:0] CAP = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam int LATENCY = 101;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int DIRECTED_ROWS = 14;
	// An index past the last register.
	localparam logic [2:0] REG_NONE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	lcpf_pair_if   pair_ch ();
	lcpf_result_if res_ch ();
	lcpf_cfg_if    cfg_ch ();

	lj_coulomb_pair_force_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_in(pair_ch.sink),
		.result_out(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	// Local copy of the register file, updated as each write beat lands.
	logic [63:0] box_q, sigma_q, eps_q, qh_q, qo_q, kc_q;

	lcpf_pkg::result_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 72;
	bit hold_off = 1'b0;
	bit sending = 1'b0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Unsigned (a*b)>>FRAC_BITS saturated at the wide cap.
	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> lcpf_pkg::FRAC_BITS;
		return (p > {64'd0, CAP}) ? CAP : p[63:0];
	endfunction

	function automatic logic [63:0] int_mul(input logic [63:0] a, input logic [63:0] k);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, k};
		return (p > {64'd0, CAP}) ? CAP : p[63:0];
	endfunction

	function automatic logic signed [63:0] apply_sign(input bit neg, input logic [63:0] m);
		logic [63:0] c;
		c = (m > CAP) ? CAP : m;
		return neg ? -$signed(c) : $signed(c);
	endfunction

	function automatic logic signed [63:0] lead_diff(input logic [63:0] big, input logic [63:0] sm);
		if (big >= CAP) return $signed(CAP);
		return $signed(big) - $signed(sm);
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [47:0] clamp48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sd140737488355328) return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	// Force on atom i and pair energy for one pair under the current registers.
	function automatic lcpf_pkg::result_t pair_force(input lcpf_pkg::pair_t p);
		lcpf_pkg::result_t r;
		logic signed [63:0] d [3];
		logic [63:0] ad [3];
		logic [63:0] mx, r2, root, inv, inv2, sig, eps, x, x2, x6, x12, qq, kq, a;
		logic signed [63:0] pi, pj, qi, qj, d1, d2, elj, ecoul, ta, tb, fs, energy;
		logic [1:0] c;
		int s;
		bit both, negq;
		mx = 0;
		r2 = 0;
		s = 0;
		for (int ax = 0; ax < 3; ax++) begin
			case (ax)
				0: begin pi = p.first_x; pj = p.second_x; end
				1: begin pi = p.first_y; pj = p.second_y; end
				default: begin pi = p.first_z; pj = p.second_z; end
			endcase
			c = p.image_code[2*ax +: 2];
			if (c == lcpf_pkg::IMG_ADD) pj += $signed(box_q);
			else if (c == lcpf_pkg::IMG_SUB) pj -= $signed(box_q);
			d[ax] = pj - pi;
			ad[ax] = mag(d[ax]);
			if (ad[ax] > mx) mx = ad[ax];
		end
		r.batch_end_out = p.batch_end;
		if (mx == 0) begin
			r.force_x = lcpf_pkg::OUT_MAX;
			r.force_y = lcpf_pkg::OUT_MAX;
			r.force_z = lcpf_pkg::OUT_MAX;
			r.pair_energy = lcpf_pkg::OUT_MAX;
			r.zero_distance = 1'b1;
			return r;
		end
		r.zero_distance = 1'b0;
		while ((mx >> s) >= 64'h8000_0000) s++;
		for (int ax = 0; ax < 3; ax++) begin
			a = ad[ax] >> s;
			r2 += a * a;
		end
		root = int_sqrt(r2);
		inv = (64'd1 << (2 * lcpf_pkg::FRAC_BITS)) / (root << s);
		inv2 = fx_mul(inv, inv);
		both = p.first_is_oxygen && p.second_is_oxygen;
		sig = both ? sigma_q : 0;
		eps = both ? eps_q : 0;
		x = fx_mul(sig, inv);
		x2 = fx_mul(x, x);
		x6 = fx_mul(fx_mul(x2, x2), x2);
		x12 = fx_mul(x6, x6);
		qi = $signed(p.first_is_oxygen ? qo_q[31:0] : qh_q[31:0]);
		qj = $signed(p.second_is_oxygen ? qo_q[31:0] : qh_q[31:0]);
		negq = (qi < 0) != (qj < 0);
		qq = (mag(qi) * mag(qj)) >> lcpf_pkg::FRAC_BITS;
		kq = fx_mul(kc_q, qq);
		d1 = lead_diff(x12, x6);
		elj = apply_sign(d1 < 0, int_mul(fx_mul(eps, mag(d1)), 4));
		ecoul = apply_sign(negq, fx_mul(kq, inv));
		energy = elj + ecoul;
		d2 = -lead_diff(int_mul(x12, 2), x6);
		ta = apply_sign(d2 < 0, int_mul(fx_mul(fx_mul(eps, inv2), mag(d2)), 24));
		tb = apply_sign(negq, fx_mul(fx_mul(kq, inv2), inv));
		fs = ta - tb;
		if (fs > $signed(CAP)) fs = $signed(CAP);
		if (fs < -$signed(CAP)) fs = -$signed(CAP);
		r.force_x = clamp48(apply_sign((d[0] < 0) != (fs < 0), fx_mul(ad[0], mag(fs))));
		r.force_y = clamp48(apply_sign((d[1] < 0) != (fs < 0), fx_mul(ad[1], mag(fs))));
		r.force_z = clamp48(apply_sign((d[2] < 0) != (fs < 0), fx_mul(ad[2], mag(fs))));
		r.pair_energy = clamp48(energy);
		return r;
	endfunction

	// Reset values of the registers.
	initial begin
		box_q = lcpf_pkg::RST_BOX_SIZE;
		sigma_q = lcpf_pkg::RST_OXYGEN_SIGMA;
		eps_q = lcpf_pkg::RST_OXYGEN_EPSILON;
		qh_q = lcpf_pkg::RST_HYDROGEN_CHARGE;
		qo_q = lcpf_pkg::RST_OXYGEN_CHARGE;
		kc_q = lcpf_pkg::RST_COULOMB_SCALE;
	end

	// Every accepted pair beat queues its prediction; every result beat is checked.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (pair_ch.valid && pair_ch.ready)
			expected_q.push_back(pair_force(pair_ch.data));
		if (res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected beat", 64'd0, 64'd0);
			end else begin
				lcpf_pkg::result_t w, g;
				w = expected_q.pop_front();
				g = res_ch.data;
				if (g.force_x !== w.force_x) report("force_x", g.force_x, w.force_x);
				if (g.force_y !== w.force_y) report("force_y", g.force_y, w.force_y);
				if (g.force_z !== w.force_z) report("force_z", g.force_z, w.force_z);
				if (g.pair_energy !== w.pair_energy)
					report("pair_energy", g.pair_energy, w.pair_energy);
				if (g.zero_distance !== w.zero_distance)
					report("zero_distance", g.zero_distance, w.zero_distance);
				if (g.batch_end_out !== w.batch_end_out)
					report("batch_end_out", g.batch_end_out, w.batch_end_out);
			end
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.reg_index)
				lcpf_pkg::REG_BOX_SIZE: box_q <= cfg_ch.wdata[30:0];
				lcpf_pkg::REG_OXYGEN_SIGMA: sigma_q <= cfg_ch.wdata[30:0];
				lcpf_pkg::REG_OXYGEN_EPSILON: eps_q <= cfg_ch.wdata[30:0];
				lcpf_pkg::REG_HYDROGEN_CHARGE: qh_q <= cfg_ch.wdata;
				lcpf_pkg::REG_OXYGEN_CHARGE: qo_q <= cfg_ch.wdata;
				lcpf_pkg::REG_COULOMB_SCALE: kc_q <= cfg_ch.wdata;
				default: ;
			endcase
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL lj_coulomb_pair_force_top");
			$finish;
		end
	end

	// The receiver drops ready at random; during a hold-off it stays low throughout.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// A long receiver stall while the sender keeps offering pairs, which fills the
	// pipeline and must push back on the input.
	initial begin
		wait (sending);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drive one beat; valid stays high between back-to-back beats.
	task automatic send_pair(input lcpf_pkg::pair_t p);
		if ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		pair_ch.valid <= 1'b1;
		pair_ch.data <= p;
		@(posedge clk);
		while (!pair_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		pair_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(3);
			default: return $signed($urandom_range(67108864)) - 32'sd33554432;
		endcase
	endfunction

	function automatic lcpf_pkg::pair_t rnd_pair();
		lcpf_pkg::pair_t p;
		p.first_x = rnd_pos();
		p.first_y = rnd_pos();
		p.first_z = rnd_pos();
		// Mostly a nearby partner so that distances stay physical.
		if ($urandom_range(3) != 0) begin
			p.second_x = p.first_x + ($signed($urandom_range(16777216)) - 32'sd8388608);
			p.second_y = p.first_y + ($signed($urandom_range(16777216)) - 32'sd8388608);
			p.second_z = p.first_z + ($signed($urandom_range(16777216)) - 32'sd8388608);
		end else begin
			p.second_x = rnd_pos();
			p.second_y = rnd_pos();
			p.second_z = rnd_pos();
		end
		p.first_is_oxygen = $urandom_range(1);
		p.second_is_oxygen = $urandom_range(1);
		p.image_code = $urandom_range(63);
		p.batch_end = ($urandom_range(7) == 0);
		return p;
	endfunction

	// Directed rows: positions i and j, types, image code, batch marker.
	// Only the zero-distance rows carry the fixed flag.
	typedef struct {
		lcpf_pkg::pair_t p;
		bit fixed;
	} row_t;
	row_t rows [DIRECTED_ROWS];

	initial begin
		lcpf_pkg::pair_t z;
		z = '0;
		rows[0] = '{z, 1'b1};
		rows[1] = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 6'b111111, 1'b1}, 1'b1};
		rows[2] = '{'{0, 0, 0, 32'h0050_0000, 0, 0, 1'b1, 1'b1, 6'b000000, 1'b0}, 1'b0};
		rows[3] = '{'{0, 0, 0, 32'h0050_0000, 0, 0, 1'b0, 1'b1, 6'b000000, 1'b0}, 1'b0};
		rows[4] = '{'{0, 0, 0, 0, 32'h0018_0000, 0, 1'b1, 1'b0, 6'b000000, 1'b0}, 1'b0};
		rows[5] = '{'{0, 0, 0, 0, 0, 32'h0030_0000, 1'b0, 1'b0, 6'b000000, 1'b1}, 1'b0};
		rows[6] = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 6'b010101, 1'b0}, 1'b0};
		rows[7] = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 6'b101010, 1'b0}, 1'b0};
		rows[8] = '{'{0, 0, 0, 0, 0, 32'h0000_0001, 1'b1, 1'b1, 6'b000000, 1'b0}, 1'b0};
		rows[9] = '{'{0, 0, 0, 32'hFD00_0000, 0, 0, 1'b1, 1'b1, 6'b000001, 1'b0}, 1'b0};
		rows[10] = '{'{0, 0, 0, 32'h0300_0000, 32'h0300_0000, 0, 1'b1, 1'b1, 6'b001010,
			1'b1}, 1'b1};
		rows[11] = '{'{32'h0100_0000, 0, 0, 32'h0100_0000, 0, 0, 1'b0, 1'b0, 6'b111111,
			1'b0}, 1'b1};
		rows[12] = '{'{32'hFFFF_FFFF, 32'h1234_5678, 32'hEDCB_A987, 0, 0, 0, 1'b1, 1'b0,
			6'b100100, 1'b1}, 1'b0};
		rows[13] = '{'{0, 0, 0, 0, 32'h0004_0000, 32'h0004_0000, 1'b1, 1'b1, 6'b000000,
			1'b0}, 1'b0};
	end

	// Register settings per random phase: box, sigma, epsilon, qH, qO, Coulomb constant.
	logic [31:0] phase_regs [4][6] = '{
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF},
		'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0000},
		'{32'h0200_0000, 32'h0066_0000, 32'h0100_0000, 32'hFF80_0000, 32'h0100_0000,
			32'h8000_0000},
		'{32'(lcpf_pkg::RST_BOX_SIZE), 32'(lcpf_pkg::RST_OXYGEN_SIGMA),
			32'(lcpf_pkg::RST_OXYGEN_EPSILON), lcpf_pkg::RST_HYDROGEN_CHARGE,
			lcpf_pkg::RST_OXYGEN_CHARGE, lcpf_pkg::RST_COULOMB_SCALE}
	};

	initial begin
		pair_pending_init();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sending = 1'b1;

		// Directed part at reset register values. Zero-distance rows are checked
		// against the zero-distance flag of the prediction as well.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (rows[i].fixed && pair_force(rows[i].p).zero_distance !== 1'b1)
				report("directed zero distance row", i, 0);
			send_pair(rows[i].p);
		end
		drain();

		// Random part in four register settings, idling pattern rotating.
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 6; k++)
				write_reg(3'(lcpf_pkg::REG_BOX_SIZE + k), phase_regs[ph][k]);
			// An index past the last register must be ignored.
			write_reg(REG_NONE, $urandom);
			if (ph == 2) begin
				send_idle_pct = 72;
				recv_idle_pct = 8;
			end else if (ph == 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < 285; n++)
				send_pair(rnd_pair());
			drain();
		end

		if (errors == 0) begin
			$display("PASS lj_coulomb_pair_force_top");
		end else begin
			$display("FAIL lj_coulomb_pair_force_top");
		end
		$finish;
	end

	task automatic pair_pending_init();
		pair_ch.valid = 1'b0;
		pair_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = lcpf_pkg::REG_BOX_SIZE;
		cfg_ch.wdata = '0;
	endtask

endmodule

>>> files.f
hw/rtl/lcpf_pkg.sv
hw/rtl/lcpf_intf.sv
hw/rtl/lcpf_qmul.sv
hw/rtl/lcpf_sqrt.sv
hw/rtl/lcpf_recip.sv
hw/rtl/lj_coulomb_pair_force_top.sv
bench/tb_lj_coulomb_pair_force_top.sv
